/* rtl/keyframe_pose_interpolator_top_macros.svh */
// Assertion macros shared by the keyframe pose player.
// Included by the files that carry concurrent assertions.
`ifndef KEYFRAME_POSE_INTERPOLATOR_TOP_MACROS_SVH
`define KEYFRAME_POSE_INTERPOLATOR_TOP_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define KPI_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Implication whose consequent is checked in the next cycle.
`define KPI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

/* rtl/kpi_pkg.sv */
// Package for the keyframe pose player: item kinds, widths, lane control.
// No dependencies.
package kpi_pkg;
    localparam int unsigned MaxCh = 9;
    localparam int unsigned WordW = 32;
    typedef enum logic [1:0] {
        K_SAVE = 2'd0,
        K_PLAY = 2'd1,
        K_TICK = 2'd2,
        K_NONE = 2'd3
    } t_kind;
    // Per-lane command from the sequencer.
    typedef struct packed {
        logic load;   // load the pose word
        logic add;    // saturating add of the increment
        logic div_go; // start the increment division
    } t_lane_ctl;
endpackage

/* rtl/kpi_lane.sv */
// One pose channel: current value, increment, and a serial signed divider.
// Depends on kpi_pkg.
module kpi_lane
    import kpi_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_lane_ctl           i_ctl,
    input  logic [WordW-1:0]    i_load,
    input  logic [WordW-1:0]    i_frm_a,
    input  logic [WordW-1:0]    i_frm_b,
    input  logic [15:0]         i_div,
    output logic [WordW-1:0]    o_pose,
    output logic                o_busy
);
    logic signed [WordW-1:0] r_pose, r_inc;
    logic [32:0] r_rem_q;  // dividend magnitude shifting into quotient
    logic [16:0] r_rem;
    logic [5:0]  r_cnt;
    logic        r_busy, r_neg;
    logic signed [WordW:0] w_diff;
    logic [32:0] w_mag;
    logic [16:0] w_try;
    logic [16:0] w_sh;
    logic [33:0] w_q_s;
    logic signed [WordW:0] w_sum;

    assign w_diff = {i_frm_b[WordW-1], i_frm_b} - {i_frm_a[WordW-1], i_frm_a};
    assign w_mag  = w_diff[WordW] ? 33'(-w_diff) : 33'(w_diff);
    assign w_sh   = {r_rem[15:0], r_rem_q[32]};
    assign w_try  = w_sh - {1'b0, i_div};
    assign w_sum  = {r_pose[WordW-1], r_pose} + {r_inc[WordW-1], r_inc};
    // Final quotient, signed, then saturated.
    assign w_q_s  = r_neg ? -{1'b0, r_rem_q} : {1'b0, r_rem_q};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pose <= '0;
            r_inc  <= '0;
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (i_ctl.load) begin
                r_pose <= i_load;
            end else if (i_ctl.add) begin
                if (w_sum[WordW] != w_sum[WordW-1]) begin
                    r_pose <= w_sum[WordW] ? {1'b1, {(WordW-1){1'b0}}}
                                           : {1'b0, {(WordW-1){1'b1}}};
                end else begin
                    r_pose <= w_sum[WordW-1:0];
                end
            end
            if (i_ctl.div_go) begin
                r_rem_q <= w_mag;
                r_rem   <= '0;
                r_neg   <= w_diff[WordW];
                r_cnt   <= 6'd33;
                r_busy  <= 1'b1;
            end else if (r_busy) begin
                if (r_cnt != '0) begin
                    if (!w_try[16]) begin
                        r_rem   <= w_try;
                        r_rem_q <= {r_rem_q[31:0], 1'b1};
                    end else begin
                        r_rem   <= w_sh;
                        r_rem_q <= {r_rem_q[31:0], 1'b0};
                    end
                    r_cnt <= r_cnt - 6'd1;
                end else begin
                    r_busy <= 1'b0;
                    if (w_q_s[33] == 1'b0 && w_q_s[32:31] != 2'b00) begin
                        r_inc <= {1'b0, {(WordW-1){1'b1}}};
                    end else if (w_q_s[33] && w_q_s[32:31] != 2'b11) begin
                        r_inc <= {1'b1, {(WordW-1){1'b0}}};
                    end else begin
                        r_inc <= w_q_s[WordW-1:0];
                    end
                end
            end
        end
    end

    assign o_pose = r_pose;
    assign o_busy = r_busy;
endmodule

/* rtl/keyframe_pose_interpolator_top.sv */
// Keyframe pose player, nine-lane top level with frame memory and sequencer.
// Save, stop, none and a tick without a segment change go straight to S_OUT; play start or
// segment change: memory read in S_RD, division start in S_DIV, wait in S_WAIT for the
// per-lane radix-2 divider, then S_OUT. The next beat is taken in the cycle after the result
// beat leaves, so beats never overlap. Synchronous active-low reset clears pose, increments,
// counters and the playing flag; the frame memory is not cleared.
module keyframe_pose_interpolator_top
    import kpi_pkg::*;
#(
    parameter int unsigned FRAMES   = 32,
    parameter int unsigned CHANNELS = 9
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [295:0] s_axis_tdata,  // pos_x..left_arm_angle (32 each) from bit 0
    input  logic [1:0]   s_axis_tuser,  // kind
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [295:0] m_axis_tdata,  // out_pos_x..out_left_arm_angle from bit 0
    output logic         m_axis_tuser,  // playing
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [15:0]  i_cfg_data
);
    localparam int unsigned FW = $clog2(FRAMES + 1);
    localparam int unsigned AW = $clog2(FRAMES);

    typedef enum logic [2:0] {S_IDLE, S_RD, S_DIV, S_WAIT, S_OUT} t_state;
    t_state r_state;

    logic [WordW*MaxCh-1:0] r_mem [FRAMES];
    logic [WordW*MaxCh-1:0] r_rd_a, r_rd_b;
    logic [15:0]  r_steps, r_ctr;
    logic [FW-1:0] r_fcnt;
    logic [FW-1:0] r_seg;
    logic         r_play, r_vld, r_first;
    logic [AW-1:0] w_ra;
    logic [15:0]  w_steps;
    t_lane_ctl    w_ctl;
    logic [WordW-1:0] w_pose [MaxCh];
    logic [MaxCh-1:0] w_busy;
    logic         w_acc;
    t_kind        w_kind;

    assign w_steps = (r_steps == 16'd0) ? 16'd1 : r_steps;
    assign w_kind  = t_kind'(s_axis_tuser);
    assign s_axis_tready = (r_state == S_IDLE) && !r_vld;
    assign w_acc  = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready = 1'b1;
    assign w_ra = r_seg[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (w_acc && w_kind == K_SAVE && r_fcnt < FW'(FRAMES)) begin
            r_mem[r_fcnt[AW-1:0]] <= s_axis_tdata[WordW*MaxCh-1:0];
        end
        r_rd_a <= r_mem[w_ra];
        r_rd_b <= r_mem[AW'(w_ra + AW'(1))];
    end

    always_comb begin
        w_ctl = '0;
        if (r_state == S_IDLE && w_acc && w_kind == K_SAVE) w_ctl.load = 1'b1;
        if (r_state == S_DIV) begin
            w_ctl.div_go = 1'b1;
            w_ctl.load   = r_first;
        end
        if (r_state == S_IDLE && w_acc && w_kind == K_TICK && r_play && r_ctr < w_steps)
            w_ctl.add = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_steps <= 16'd60;
            r_fcnt  <= '0;
            r_seg   <= '0;
            r_ctr   <= '0;
            r_play  <= 1'b0;
            r_vld   <= 1'b0;
            r_first <= 1'b0;
        end else begin
            if (i_cfg_valid) r_steps <= i_cfg_data;
            if (m_axis_tvalid && m_axis_tready) r_vld <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        r_state <= S_OUT;
                        case (w_kind)
                            K_SAVE: if (r_fcnt < FW'(FRAMES)) r_fcnt <= r_fcnt + FW'(1);
                            K_PLAY: begin
                                if (!r_play && r_fcnt > FW'(1)) begin
                                    r_play <= 1'b1;
                                    r_seg  <= '0;
                                    r_ctr  <= '0;
                                    r_first <= 1'b1;
                                    r_state <= S_RD;
                                end else begin
                                    r_play <= 1'b0;
                                end
                            end
                            K_TICK: begin
                                if (r_play) begin
                                    if (r_ctr >= w_steps) begin
                                        if (r_seg + FW'(1) > r_fcnt - FW'(2)) begin
                                            r_seg  <= '0;
                                            r_play <= 1'b0;
                                        end else begin
                                            r_seg   <= r_seg + FW'(1);
                                            r_ctr   <= '0;
                                            r_first <= 1'b0;
                                            r_state <= S_RD;
                                        end
                                    end else begin
                                        r_ctr <= r_ctr + 16'd1;
                                    end
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_RD:   r_state <= S_DIV;
                S_DIV:  r_state <= S_WAIT;
                S_WAIT: if (w_busy == '0) r_state <= S_OUT;
                S_OUT: begin
                    r_vld   <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // S_RD reads memory in the cycle the segment address is set; data valid in S_DIV.
    for (genvar g = 0; g < MaxCh; g++) begin : g_lane
        if (g < CHANNELS) begin : g_on
            kpi_lane u_lane (
                .i_clk  (i_clk),
                .i_rst_n(i_rst_n),
                .i_ctl  (w_ctl),
                .i_load (w_ctl.div_go ? r_rd_a[g*WordW +: WordW]
                                      : s_axis_tdata[g*WordW +: WordW]),
                .i_frm_a(r_rd_a[g*WordW +: WordW]),
                .i_frm_b(r_rd_b[g*WordW +: WordW]),
                .i_div  (w_steps),
                .o_pose (w_pose[g]),
                .o_busy (w_busy[g])
            );
        end else begin : g_off
            assign w_pose[g] = '0;
            assign w_busy[g] = 1'b0;
        end
        assign m_axis_tdata[g*WordW +: WordW] = w_pose[g];
    end
    assign m_axis_tdata[295:WordW*MaxCh] = '0;
    assign m_axis_tvalid = r_vld;
    assign m_axis_tuser  = r_play;

    `include "keyframe_pose_interpolator_top_macros.svh"
    `KPI_ASSERT_IMPL(a_no_accept_busy, i_clk, i_rst_n, r_state != S_IDLE, !s_axis_tready)
    `KPI_ASSERT_IMPL(a_fcnt_max, i_clk, i_rst_n, 1'b1, r_fcnt <= FW'(FRAMES))
    `KPI_ASSERT_NEXT(a_div_start, i_clk, i_rst_n, r_state == S_DIV, w_busy != '0 || CHANNELS == 0)
endmodule
